// ===== src/assert_macros.svh =====
// Assertion macros shared by the tracker modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is low.
`define GNBT_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define GNBT_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/gnbt_pkg.sv =====
// Package: shared types and constants of the gated nearest blob tracker.
package gnbt_pkg;

  localparam int IMAGE_WIDTH   = 1024;
  localparam int REGION_HEIGHT = 256;

  localparam int X_W     = 10;
  localparam int Y_W     = 8;
  localparam int AREA_W  = 18;
  localparam int DIST_W  = 21;
  localparam int GATE_W  = 10;
  localparam int GSQ_W   = 2 * GATE_W;
  localparam int STEER_W = 11;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 18;

  localparam logic [CFG_IDX_W-1:0] CFG_MIN_AREA = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GATE     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y = 2'd3;

  localparam logic [AREA_W-1:0] MIN_AREA_RST = 18'd50;
  localparam logic [GSQ_W-1:0]  GATE_SQ_RST  = 20'd10000;
  localparam logic [X_W-1:0]    CENTER_X_RST = 10'd320;
  localparam logic [Y_W-1:0]    CENTER_Y_RST = 8'd60;

  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  typedef struct packed {
    logic [AREA_W-1:0] min_area;
    logic [GSQ_W-1:0]  gate_sq;
    logic [X_W-1:0]    center_x;
    logic [Y_W-1:0]    center_y;
  } cfg_t;

  typedef struct packed {
    logic              cand;
    logic [X_W-1:0]    x;
    logic [Y_W-1:0]    y;
    logic [AREA_W-1:0] area;
    logic              last;
  } blob_item_t;

endpackage

// ===== src/gnbt_front.sv =====
// Front end: accepts blob transactions and marks noise and off-image blobs as non-candidates.
module gnbt_front #(
  parameter int IMAGE_WIDTH   = gnbt_pkg::IMAGE_WIDTH,
  parameter int REGION_HEIGHT = gnbt_pkg::REGION_HEIGHT
) (
  input  logic                      in_push,
  input  logic                      in_blob_valid,
  input  logic [gnbt_pkg::X_W-1:0]  in_blob_x,
  input  logic [gnbt_pkg::Y_W-1:0]  in_blob_y,
  input  logic [gnbt_pkg::AREA_W-1:0] in_blob_area,
  input  logic                      in_frame_last,
  input  gnbt_pkg::cfg_t            cfg,
  input  logic                      q_full,
  output logic                      q_wr,
  output gnbt_pkg::blob_item_t      q_wr_item
);
  import gnbt_pkg::*;

  logic in_image;

  assign in_image = (32'(in_blob_x) < IMAGE_WIDTH) && (32'(in_blob_y) < REGION_HEIGHT);
  assign q_wr     = in_push && !q_full;

  always_comb begin
    q_wr_item.cand = in_blob_valid && (in_blob_area >= cfg.min_area) && in_image;
    q_wr_item.x    = in_blob_x;
    q_wr_item.y    = in_blob_y;
    q_wr_item.area = in_blob_area;
    q_wr_item.last = in_frame_last;
  end

endmodule

// ===== src/gnbt_queue.sv =====
// Short queue between the front end and the tracking back end.
`include "assert_macros.svh"
module gnbt_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 wr,
  input  gnbt_pkg::blob_item_t wr_item,
  input  logic                 rd,
  output gnbt_pkg::blob_item_t rd_item,
  output logic                 full,
  output logic                 empty
);
  import gnbt_pkg::*;

  blob_item_t             entry_r [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QUEUE_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QUEUE_CNT_W-1:0] count_r, count_nxt;

  function automatic logic [QUEUE_PTR_W-1:0] ptr_inc(input logic [QUEUE_PTR_W-1:0] p);
    logic [QUEUE_PTR_W-1:0] r;
    if (32'(p) == QUEUE_DEPTH - 1) begin
      r = '0;
    end else begin
      r = p + 1'b1;
    end
    return r;
  endfunction

  assign full    = (32'(count_r) == QUEUE_DEPTH);
  assign empty   = (count_r == '0);
  assign rd_item = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = rd ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    count_nxt  = count_r;
    if (wr && !rd) begin
      count_nxt = count_r + 1'b1;
    end else if (rd && !wr) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      entry_r[wr_ptr_r] <= wr_item;
    end
  end

  `GNBT_ASSERT(a_count_bound, clk, rst_n, (32'(count_r) <= QUEUE_DEPTH), "queue count overflow")
  `GNBT_ASSERT(a_no_underflow, clk, rst_n, (rd |-> !empty), "queue read while empty")
  `GNBT_ASSERT(a_wr_grows, clk, rst_n, ((wr && !rd) |=> (count_r == $past(count_r) + 1'b1)), "queue count did not grow on write")

endmodule

// ===== src/gnbt_back.sv =====
// Back end: gated nearest-blob selection, frame commit and result register.
`include "assert_macros.svh"
module gnbt_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  gnbt_pkg::cfg_t               cfg,
  input  logic                         q_empty,
  input  gnbt_pkg::blob_item_t         q_item,
  output logic                         q_rd,
  input  logic                         out_pop,
  output logic                         out_empty,
  output logic signed [gnbt_pkg::STEER_W-1:0] out_steer_error,
  output logic                         out_target_found,
  output logic [gnbt_pkg::X_W-1:0]     out_target_x,
  output logic [gnbt_pkg::Y_W-1:0]     out_target_y,
  output logic                         out_target_locked
);
  import gnbt_pkg::*;

  logic              locked_r;
  logic [X_W-1:0]    prev_x_r;
  logic [Y_W-1:0]    prev_y_r;
  logic [AREA_W-1:0] prev_area_r;
  logic [X_W-1:0]    best_x_r, best_x_nxt;
  logic [Y_W-1:0]    best_y_r, best_y_nxt;
  logic [AREA_W-1:0] best_area_r, best_area_nxt;
  logic [DIST_W-1:0] best_dist_r, best_dist_nxt;
  logic              best_found_r, best_found_nxt;

  logic               out_valid_r;
  logic [STEER_W-1:0] steer_r;
  logic               found_r;
  logic [X_W-1:0]     tx_r;
  logic [Y_W-1:0]     ty_r;
  logic               tlocked_r;

  logic [X_W-1:0]    ref_x, dx;
  logic [Y_W-1:0]    ref_y, dy;
  logic [19:0]       dx_sq;
  logic [15:0]       dy_sq;
  logic [DIST_W-1:0] dsq;
  logic [DIST_W-1:0] five_prev;
  logic              gate_ok, area_ok, better, take_last;

  assign q_rd      = !q_empty && (!q_item.last || !out_valid_r || out_pop);
  assign take_last = q_rd && q_item.last;

  always_comb begin
    ref_x     = locked_r ? prev_x_r : cfg.center_x;
    ref_y     = locked_r ? prev_y_r : cfg.center_y;
    dx        = (q_item.x > ref_x) ? q_item.x - ref_x : ref_x - q_item.x;
    dy        = (q_item.y > ref_y) ? q_item.y - ref_y : ref_y - q_item.y;
    dx_sq     = 20'(dx) * 20'(dx);
    dy_sq     = 16'(dy) * 16'(dy);
    dsq       = {1'b0, dx_sq} + DIST_W'(dy_sq);
    five_prev = {1'b0, prev_area_r, 2'b00} + DIST_W'(prev_area_r);
    gate_ok   = dsq < {1'b0, cfg.gate_sq};
    area_ok   = ({q_item.area, 1'b0} > {1'b0, prev_area_r})
                && (DIST_W'(q_item.area) < five_prev);
    better    = q_item.cand && (!locked_r || (gate_ok && area_ok)) && (dsq < best_dist_r);

    best_x_nxt     = better ? q_item.x : best_x_r;
    best_y_nxt     = better ? q_item.y : best_y_r;
    best_area_nxt  = better ? q_item.area : best_area_r;
    best_dist_nxt  = better ? dsq : best_dist_r;
    best_found_nxt = best_found_r || better;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      locked_r     <= 1'b0;
      prev_x_r     <= '0;
      prev_y_r     <= '0;
      prev_area_r  <= '0;
      best_dist_r  <= '1;
      best_found_r <= 1'b0;
    end else if (q_rd) begin
      if (q_item.last) begin
        best_dist_r  <= '1;
        best_found_r <= 1'b0;
        if (best_found_nxt) begin
          locked_r    <= 1'b1;
          prev_x_r    <= best_x_nxt;
          prev_y_r    <= best_y_nxt;
          prev_area_r <= best_area_nxt;
        end
      end else begin
        best_dist_r  <= best_dist_nxt;
        best_found_r <= best_found_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_rd) begin
      best_x_r    <= best_x_nxt;
      best_y_r    <= best_y_nxt;
      best_area_r <= best_area_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (take_last) begin
      out_valid_r <= 1'b1;
    end else if (out_pop) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take_last) begin
      found_r   <= best_found_nxt;
      steer_r   <= best_found_nxt ? (STEER_W'(cfg.center_x) - STEER_W'(best_x_nxt)) : '0;
      tx_r      <= best_found_nxt ? best_x_nxt : prev_x_r;
      ty_r      <= best_found_nxt ? best_y_nxt : prev_y_r;
      tlocked_r <= locked_r || best_found_nxt;
    end
  end

  assign out_empty         = !out_valid_r;
  assign out_steer_error   = signed'(steer_r);
  assign out_target_found  = found_r;
  assign out_target_x      = tx_r;
  assign out_target_y      = ty_r;
  assign out_target_locked = tlocked_r;

  `GNBT_ASSERT(a_result_from_frame_end, clk, rst_n, ($rose(out_valid_r) |-> $past(take_last)), "result without frame end")
  `GNBT_ASSERT(a_found_locks, clk, rst_n, ((out_valid_r && found_r) |-> tlocked_r), "found target not locked")
  `GNBT_ASSERT(a_no_pick_no_steer, clk, rst_n, ((out_valid_r && !found_r) |-> (steer_r == '0)), "steer error without pick")

endmodule

// ===== src/gated_nearest_blob_tracker_top.sv =====
// A frame-end transaction passes through the queue register and then the result register before it shows on out_.
// Throughput: one blob transaction per cycle while in_full is low; blob selection is a single compare stage.
// A frame end waits only while the previous result is unpopped; a pop frees it the same cycle.
// Reset (rst_n low, synchronous): unlocked, previous target 0, queue and result empty, configuration to defaults.
// Configuration writes are taken every cycle (cfg_ready is always high).
module gated_nearest_blob_tracker_top #(
  parameter int IMAGE_WIDTH   = gnbt_pkg::IMAGE_WIDTH,
  parameter int REGION_HEIGHT = gnbt_pkg::REGION_HEIGHT
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_push,
  output logic                                 in_full,
  input  logic                                 in_blob_valid,
  input  logic [gnbt_pkg::X_W-1:0]             in_blob_x,
  input  logic [gnbt_pkg::Y_W-1:0]             in_blob_y,
  input  logic [gnbt_pkg::AREA_W-1:0]          in_blob_area,
  input  logic                                 in_frame_last,
  output logic                                 out_empty,
  input  logic                                 out_pop,
  output logic signed [gnbt_pkg::STEER_W-1:0]  out_steer_error,
  output logic                                 out_target_found,
  output logic [gnbt_pkg::X_W-1:0]             out_target_x,
  output logic [gnbt_pkg::Y_W-1:0]             out_target_y,
  output logic                                 out_target_locked,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [gnbt_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [gnbt_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
  import gnbt_pkg::*;

  cfg_t       cfg_r;
  logic       q_wr, q_rd, q_full, q_empty;
  blob_item_t q_wr_item, q_rd_item;
  logic [GATE_W-1:0] gate_wdata;

  assign cfg_ready  = 1'b1;
  assign gate_wdata = cfg_wdata[GATE_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_area <= MIN_AREA_RST;
      cfg_r.gate_sq  <= GATE_SQ_RST;
      cfg_r.center_x <= CENTER_X_RST;
      cfg_r.center_y <= CENTER_Y_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_MIN_AREA: cfg_r.min_area <= cfg_wdata[AREA_W-1:0];
        CFG_GATE:     cfg_r.gate_sq  <= GSQ_W'(gate_wdata) * GSQ_W'(gate_wdata);
        CFG_CENTER_X: cfg_r.center_x <= cfg_wdata[X_W-1:0];
        CFG_CENTER_Y: cfg_r.center_y <= cfg_wdata[Y_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign in_full = q_full;

  gnbt_front #(
    .IMAGE_WIDTH   (IMAGE_WIDTH),
    .REGION_HEIGHT (REGION_HEIGHT)
  ) u_front (
    .in_push       (in_push),
    .in_blob_valid (in_blob_valid),
    .in_blob_x     (in_blob_x),
    .in_blob_y     (in_blob_y),
    .in_blob_area  (in_blob_area),
    .in_frame_last (in_frame_last),
    .cfg           (cfg_r),
    .q_full        (q_full),
    .q_wr          (q_wr),
    .q_wr_item     (q_wr_item)
  );

  gnbt_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (q_wr),
    .wr_item (q_wr_item),
    .rd      (q_rd),
    .rd_item (q_rd_item),
    .full    (q_full),
    .empty   (q_empty)
  );

  gnbt_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg_r),
    .q_empty           (q_empty),
    .q_item            (q_rd_item),
    .q_rd              (q_rd),
    .out_pop           (out_pop),
    .out_empty         (out_empty),
    .out_steer_error   (out_steer_error),
    .out_target_found  (out_target_found),
    .out_target_x      (out_target_x),
    .out_target_y      (out_target_y),
    .out_target_locked (out_target_locked)
  );

endmodule
